// ----- rtl/lpbf_pkg.sv -----
// Package for the lidar point box filter.
// Shared constants, register indexes and the configuration struct; no dependencies.
package lpbf_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int PIXEL_FRAC_DEF  = 4;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int LANE_W          = 16;
    localparam int PIX_W           = 16;
    // quotient bits kept by the divider: clamp point is 2^40
    localparam int QUOT_W          = 41;
    localparam int T_SHIFT         = 14;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX  = 3'd4;

    localparam logic [CFG_W-1:0] ROW0_RST = 64'd16384;
    localparam logic [CFG_W-1:0] ROW1_RST = 64'd1073741824;
    localparam logic [CFG_W-1:0] ROW2_RST = 64'd70368744177664;
    localparam logic [CFG_W-1:0] INTR_RST = 64'd0;
    localparam logic [CFG_W-1:0] BOX_RST  = 64'd84444211013222700;

    typedef struct packed {
        logic [CFG_W-1:0] row0;
        logic [CFG_W-1:0] row1;
        logic [CFG_W-1:0] row2;
        logic [CFG_W-1:0] intr;
        logic [CFG_W-1:0] box;
    } t_cfg;

endpackage

// ----- rtl/lpbf_pt_if.sv -----
// Input channel of the lidar point box filter: one lidar point per transfer.
// Standalone interface, no dependencies.
interface lpbf_pt_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 cloud_end;

    modport source (output valid, point_x, point_y, point_z, cloud_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

// ----- rtl/lpbf_res_if.sv -----
// Output channel of the lidar point box filter: one result per transfer.
// Standalone interface, no dependencies.
interface lpbf_res_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic signed [15:0]   pixel_u;
    logic signed [15:0]   pixel_v;
    logic                 keep;
    logic                 out_end;

    modport source (output valid, out_x, out_y, out_z, pixel_u, pixel_v, keep, out_end,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, pixel_u, pixel_v, keep, out_end,
                     output ready);
endinterface

// ----- rtl/lidar_point_box_filter.sv -----
// Top level of the lidar point box filter: config registers, projection and box test.
// Uses lpbf_pkg, lpbf_pt_if, lpbf_res_if, lpbf_xform and lpbf_div.
//
// One lidar point goes in per cycle and one result comes out per cycle, sustained
// while the output takes every result. Stages: transform, focal multiply, divider (a
// load stage plus one stage per quotient bit, 41 bits), centre add, then box test and
// saturation. Each stage holds its item while the next one is full, so a stall at the
// output backs up stage by stage and bubbles are squeezed out; nothing is dropped or
// repeated. Points with camera depth zero or less give pixel 0,0 and keep 0.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while no point
// is in flight; unknown indexes are ignored.
module lidar_point_box_filter
    import lpbf_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int PIXEL_FRAC_BITS = PIXEL_FRAC_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpbf_pt_if.sink              i_pt,
    lpbf_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CW   = COORD_WIDTH;
    localparam int CAMW = CW + 20;           // camera coords, scale 2^14 of the point units
    localparam int NW   = LANE_W + CAMW;     // focal * |coord|
    localparam int UW   = QUOT_W + 2;        // signed pixel before saturation
    localparam int PTW  = 3 * CW + 1;        // point plus end mark
    localparam int S3W  = PTW + 3;           // plus depth-positive and two signs
    localparam logic [QUOT_W-1:0]  QLIM   = {1'b1, {(QUOT_W-1){1'b0}}};
    localparam logic signed [UW-1:0] SAT_HI = UW'(32767);
    localparam logic signed [UW-1:0] SAT_LO = -UW'(32768);

    // ---- configuration registers ----
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row0 <= ROW0_RST;
            r_cfg.row1 <= ROW1_RST;
            r_cfg.row2 <= ROW2_RST;
            r_cfg.intr <= INTR_RST;
            r_cfg.box  <= BOX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW0: r_cfg.row0 <= i_cfg_data;
                REG_ROW1: r_cfg.row1 <= i_cfg_data;
                REG_ROW2: r_cfg.row2 <= i_cfg_data;
                REG_INTR: r_cfg.intr <= i_cfg_data;
                REG_BOX:  r_cfg.box  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- transform ----
    logic                   w_xf_valid, w_xf_ready;
    logic signed [CAMW-1:0] w_xc, w_yc, w_zc;
    logic [PTW-1:0]         w_xf_side;

    lpbf_xform #(.CW(CW), .CAMW(CAMW), .SW(PTW)) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pt.valid),
        .o_ready (i_pt.ready),
        .i_px    (i_pt.point_x),
        .i_py    (i_pt.point_y),
        .i_pz    (i_pt.point_z),
        .i_side  ({i_pt.point_x, i_pt.point_y, i_pt.point_z, i_pt.cloud_end}),
        .o_valid (w_xf_valid),
        .i_ready (w_xf_ready),
        .o_xc    (w_xc),
        .o_yc    (w_yc),
        .o_zc    (w_zc),
        .o_side  (w_xf_side)
    );

    // ---- focal multiply: fx*|xc|, fy*|yc|; divisor forced to 1 for bad depth ----
    logic             r_v3;
    logic [NW-1:0]    r_nu, r_nv;
    logic [CAMW-1:0]  r_den;
    logic [S3W-1:0]   r_s3;
    logic             w_rdy3, w_div_ready;
    logic             w_pos, w_sx, w_sy;
    logic [CAMW-1:0]  w_mx, w_my;

    assign w_rdy3     = !r_v3 || w_div_ready;
    assign w_xf_ready = w_rdy3;
    assign w_pos      = w_zc > 0;
    assign w_sx       = w_xc[CAMW-1];
    assign w_sy       = w_yc[CAMW-1];
    assign w_mx       = w_sx ? CAMW'(-w_xc) : CAMW'(w_xc);
    assign w_my       = w_sy ? CAMW'(-w_yc) : CAMW'(w_yc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_rdy3) r_v3 <= w_xf_valid;
        if (w_rdy3) begin
            r_nu  <= NW'(r_cfg.intr[15:0])  * NW'(w_mx);
            r_nv  <= NW'(r_cfg.intr[31:16]) * NW'(w_my);
            r_den <= w_pos ? CAMW'(w_zc) : CAMW'(1);
            r_s3  <= {w_xf_side, w_pos, w_sx, w_sy};
        end
    end

    // ---- divide ----
    logic                 w_dv_valid, w_dv_ready;
    logic [QUOT_W-1:0]    w_qu, w_qv;
    logic                 w_ovu, w_ovv;
    logic [S3W-1:0]       w_dv_side;

    lpbf_div #(.NW(NW), .DW(CAMW), .QW(QUOT_W), .SW(S3W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (w_div_ready),
        .i_nu    (r_nu),
        .i_nv    (r_nv),
        .i_den   (r_den),
        .i_side  (r_s3),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_qu    (w_qu),
        .o_qv    (w_qv),
        .o_ovu   (w_ovu),
        .o_ovv   (w_ovv),
        .o_side  (w_dv_side)
    );

    // ---- clamp, sign, centre add ----
    logic                 r_v4;
    logic signed [UW-1:0] r_u, r_v;
    logic                 r_pos4;
    logic [PTW-1:0]       r_pt4;
    logic                 w_rdy4, w_rdy5;
    logic [QUOT_W-1:0]    w_cu, w_cv;
    logic signed [UW-1:0] w_su, w_sv;

    assign w_rdy5     = !o_res.valid || o_res.ready;
    assign w_rdy4     = !r_v4 || w_rdy5;
    assign w_dv_ready = w_rdy4;
    assign w_cu = (w_ovu || w_qu > QLIM) ? QLIM : w_qu;
    assign w_cv = (w_ovv || w_qv > QLIM) ? QLIM : w_qv;
    assign w_su = w_dv_side[1] ? -$signed(UW'(w_cu)) : $signed(UW'(w_cu));
    assign w_sv = w_dv_side[0] ? -$signed(UW'(w_cv)) : $signed(UW'(w_cv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_rdy4) r_v4 <= w_dv_valid;
        if (w_rdy4) begin
            r_pos4 <= w_dv_side[2];
            r_pt4  <= w_dv_side[S3W-1:3];
            r_u    <= w_dv_side[2] ? w_su + $signed(UW'(r_cfg.intr[47:32])) : '0;
            r_v    <= w_dv_side[2] ? w_sv + $signed(UW'(r_cfg.intr[63:48])) : '0;
        end
    end

    // ---- box test and saturation into the output register ----
    logic signed [UW-1:0] w_xmin, w_ymin, w_xmax, w_ymax;
    logic                 r_pos5;

    assign w_xmin = $signed(UW'(r_cfg.box[15:0]))  <<< PIXEL_FRAC_BITS;
    assign w_ymin = $signed(UW'(r_cfg.box[31:16])) <<< PIXEL_FRAC_BITS;
    assign w_xmax = $signed(UW'(r_cfg.box[47:32])) <<< PIXEL_FRAC_BITS;
    assign w_ymax = $signed(UW'(r_cfg.box[63:48])) <<< PIXEL_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_res.valid <= 1'b0;
        else if (w_rdy5) o_res.valid <= r_v4;
        if (w_rdy5) begin
            r_pos5        <= r_pos4;
            o_res.out_x   <= r_pt4[PTW-1 -: CW];
            o_res.out_y   <= r_pt4[2*CW -: CW];
            o_res.out_z   <= r_pt4[CW -: CW];
            o_res.out_end <= r_pt4[0];
            o_res.keep    <= r_pos4 && r_u >= w_xmin && r_u <= w_xmax
                             && r_v >= w_ymin && r_v <= w_ymax;
            o_res.pixel_u <= (r_u > SAT_HI) ? 16'sh7fff :
                             (r_u < SAT_LO) ? 16'sh8000 : r_u[PIX_W-1:0];
            o_res.pixel_v <= (r_v > SAT_HI) ? 16'sh7fff :
                             (r_v < SAT_LO) ? 16'sh8000 : r_v[PIX_W-1:0];
        end
    end

    // ---- checks ----
    // an empty output means the whole chain can take a point
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_pt.ready) else $error("input blocked with empty output");

    // rejected depth yields zero pixel and no keep
    a_bad_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !r_pos5) |-> (o_res.pixel_u == 0 && o_res.pixel_v == 0
                                      && !o_res.keep))
        else $error("bad depth result not cleared");

    // a kept point lies at or right/below the origin
    a_keep_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.keep) |-> (!o_res.pixel_u[15] && !o_res.pixel_v[15]))
        else $error("kept point with negative pixel");
endmodule

// ----- rtl/lpbf_xform.sv -----
// Rigid transform stages: nine products, then three row sums plus translation.
// Uses lpbf_pkg.
module lpbf_xform
    import lpbf_pkg::*;
#(
    parameter int CW   = COORD_WIDTH_DEF,
    parameter int CAMW = COORD_WIDTH_DEF + 20,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [CW-1:0]   i_px,
    input  logic signed [CW-1:0]   i_py,
    input  logic signed [CW-1:0]   i_pz,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [CAMW-1:0] o_xc,
    output logic signed [CAMW-1:0] o_yc,
    output logic signed [CAMW-1:0] o_zc,
    output logic [SW-1:0]          o_side
);
    localparam int PW = CW + LANE_W;

    logic                     r_v1, r_v2;
    logic signed [PW-1:0]     r_p [9];
    logic signed [LANE_W-1:0] r_t [3];
    logic [SW-1:0]            r_s1;
    logic                     w_rdy1, w_rdy2;
    logic [CFG_W-1:0]         w_row [3];
    logic signed [PW-1:0]     n_p [9];
    logic signed [CAMW-1:0]   n_sum [3];

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign w_row[0] = i_cfg.row0;
    assign w_row[1] = i_cfg.row1;
    assign w_row[2] = i_cfg.row2;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_p[3*r]   = $signed(w_row[r][15:0])  * i_px;
            n_p[3*r+1] = $signed(w_row[r][31:16]) * i_py;
            n_p[3*r+2] = $signed(w_row[r][47:32]) * i_pz;
        end
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = CAMW'(r_p[3*r]) + CAMW'(r_p[3*r+1]) + CAMW'(r_p[3*r+2])
                     + (CAMW'(r_t[r]) <<< T_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
        if (w_rdy1) begin
            r_p  <= n_p;
            r_s1 <= i_side;
            for (int r = 0; r < 3; r++) r_t[r] <= $signed(w_row[r][63:48]);
        end
        if (w_rdy2) begin
            o_xc   <= n_sum[0];
            o_yc   <= n_sum[1];
            o_zc   <= n_sum[2];
            o_side <= r_s1;
        end
    end
endmodule

// ----- rtl/lpbf_div.sv -----
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Uses lpbf_pkg.
module lpbf_div
    import lpbf_pkg::*;
#(
    parameter int NW = 52,
    parameter int DW = 36,
    parameter int QW = QUOT_W,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_nu,
    input  logic [NW-1:0] i_nv,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_qu,
    output logic [QW-1:0] o_qv,
    output logic          o_ovu,
    output logic          o_ovv,
    output logic [SW-1:0] o_side
);
    // stage 0 loads and checks overflow, stages 1..QW each resolve one bit
    logic          r_v  [QW+1];
    logic [DW-1:0] r_ru [QW+1];
    logic [DW-1:0] r_rv [QW+1];
    logic [QW-1:0] r_lu [QW+1];
    logic [QW-1:0] r_lv [QW+1];
    logic [QW-1:0] r_qu [QW+1];
    logic [QW-1:0] r_qv [QW+1];
    logic [DW-1:0] r_d  [QW+1];
    logic          r_ou [QW+1];
    logic          r_ov [QW+1];
    logic [SW-1:0] r_s  [QW+1];
    logic [QW+1:0] w_rdy;

    assign w_rdy[QW+1] = i_ready;
    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[QW];
    assign o_qu        = r_qu[QW];
    assign o_qv        = r_qv[QW];
    assign o_ovu       = r_ou[QW];
    assign o_ovv       = r_ov[QW];
    assign o_side      = r_s[QW];

    for (genvar k = 0; k <= QW; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (w_rdy[0]) r_v[0] <= i_valid;
        if (w_rdy[0]) begin
            r_ru[0] <= DW'(i_nu[NW-1:QW]);
            r_rv[0] <= DW'(i_nv[NW-1:QW]);
            r_lu[0] <= i_nu[QW-1:0];
            r_lv[0] <= i_nv[QW-1:0];
            r_qu[0] <= '0;
            r_qv[0] <= '0;
            r_d[0]  <= i_den;
            r_ou[0] <= DW'(i_nu[NW-1:QW]) >= i_den;
            r_ov[0] <= DW'(i_nv[NW-1:QW]) >= i_den;
            r_s[0]  <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DW:0] w_tu, w_tv;
        logic        w_gu, w_gv;
        assign w_tu = {r_ru[k-1], r_lu[k-1][QW-k]};
        assign w_tv = {r_rv[k-1], r_lv[k-1][QW-k]};
        assign w_gu = w_tu >= {1'b0, r_d[k-1]};
        assign w_gv = w_tv >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else if (w_rdy[k]) r_v[k] <= r_v[k-1];
            if (w_rdy[k]) begin
                r_ru[k] <= w_gu ? DW'(w_tu - {1'b0, r_d[k-1]}) : w_tu[DW-1:0];
                r_rv[k] <= w_gv ? DW'(w_tv - {1'b0, r_d[k-1]}) : w_tv[DW-1:0];
                r_lu[k] <= r_lu[k-1];
                r_lv[k] <= r_lv[k-1];
                r_qu[k] <= {r_qu[k-1][QW-2:0], w_gu};
                r_qv[k] <= {r_qv[k-1][QW-2:0], w_gv};
                r_d[k]  <= r_d[k-1];
                r_ou[k] <= r_ou[k-1];
                r_ov[k] <= r_ov[k-1];
                r_s[k]  <= r_s[k-1];
            end
        end
    end
endmodule

// ----- tb/lidar_point_box_filter_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for lidar_point_box_filter: streams lidar points under several
// register settings and checks every result against an in-bench projection model
// or typed rows. Depends on lpbf_pkg, lpbf_pt_if, lpbf_res_if and the filter RTL.
module lidar_point_box_filter_test;
    import lpbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;   // pipeline is 47 deep
    localparam int NUM_PHASES     = 8;
    localparam int RAND_PER_PHASE = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5; // first unmapped index

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic               last;
    } t_point;

    typedef struct {
        logic signed [15:0] x, y, z, u, v;
        logic               keep, last;
    } t_pixel;

    // directed row: typed result applies only under the reset registers
    typedef struct {
        logic signed [15:0] x, y, z;
        logic               last;
        logic               typed;
        logic signed [15:0] u, v;
        logic               keep;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lpbf_pt_if  #(.CW(16)) pt ();
    lpbf_res_if #(.CW(16)) res ();

    lidar_point_box_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the register file
    logic [CFG_W-1:0] row0_q, row1_q, row2_q, intr_q, box_q;

    t_pixel pixel_queue[$];
    int     errors = 0;
    int     points_sent = 0;
    int     pixels_seen = 0;
    int     kept_seen = 0;
    int     idle_cycles = 0;
    t_idle  idle_mode;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // ---------------------------------------------------------------
    // Projection model
    // ---------------------------------------------------------------
    function automatic longint lane_s(logic [63:0] r, int k);
        return longint'($signed(r[16*k +: 16]));
    endfunction

    function automatic longint cam_axis(logic [63:0] r, longint px, longint py, longint pz);
        return lane_s(r, 0) * px + lane_s(r, 1) * py + lane_s(r, 2) * pz
             + lane_s(r, 3) * 16384;
    endfunction

    // f*|num|/den truncated toward zero on the magnitude, clamped at 2^40, then centre
    function automatic longint to_pixel(logic [15:0] f, logic [15:0] c, longint num,
                                        longint den);
        logic [127:0] mag, quot;
        longint       q;
        mag  = (num < 0) ? 128'(-num) : 128'(num);
        quot = (128'(f) * mag) / 128'(den);
        if (quot > (128'd1 << 40))
            quot = 128'd1 << 40;
        q = longint'(quot[63:0]);
        return ((num < 0) ? -q : q) + longint'(c);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_pixel project_point(t_point p);
        t_pixel r;
        longint xc, yc, zc, u, v;
        r = '{x: p.x, y: p.y, z: p.z, u: '0, v: '0, keep: 1'b0, last: p.last};
        xc = cam_axis(row0_q, p.x, p.y, p.z);
        yc = cam_axis(row1_q, p.x, p.y, p.z);
        zc = cam_axis(row2_q, p.x, p.y, p.z);
        if (zc > 0) begin
            u = to_pixel(intr_q[15:0],  intr_q[47:32], xc, zc);
            v = to_pixel(intr_q[31:16], intr_q[63:48], yc, zc);
            // box test on the unclipped values, box in whole pixels
            r.keep = (u >= longint'(box_q[15:0])  * 16) && (u <= longint'(box_q[47:32]) * 16)
                  && (v >= longint'(box_q[31:16]) * 16) && (v <= longint'(box_q[63:48]) * 16);
            r.u = clip16(u);
            r.v = clip16(v);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ROW0: row0_q = data;
            REG_ROW1: row1_q = data;
            REG_ROW2: row2_q = data;
            REG_INTR: intr_q = data;
            REG_BOX:  box_q  = data;
            default: ;  // unmapped indexes are dropped by the block
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] intr, logic [63:0] box);
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
        write_reg(REG_INTR, intr);
        write_reg(REG_BOX,  box);
    endtask

    // one point transfer; the expectation is queued when the handshake completes
    task automatic send_point(t_point p);
        @(negedge i_clk);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 62) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 27)) begin
            pt.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt.valid     <= 1'b1;
        pt.point_x   <= p.x;
        pt.point_y   <= p.y;
        pt.point_z   <= p.z;
        pt.cloud_end <= p.last;
        do
            @(posedge i_clk);
        while (!pt.ready);
        pixel_queue.insert(pixel_queue.size(), project_point(p));
        points_sent++;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: res.ready <= ($urandom_range(99) >= 62);
            IDLE_BOTH: res.ready <= ($urandom_range(99) >= 27);
            default:   res.ready <= 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && res.valid && res.ready) begin
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
                errors++;
                $display("%t: unexpected result transfer u=%0d v=%0d", $realtime,
                         res.pixel_u, res.pixel_v);
            end else begin
                e = pixel_queue.pop_front();
                if (res.keep)
                    kept_seen++;
                if (res.out_x !== e.x) begin
                    errors++;
                    $display("%t: out_x exp %0d got %0d", $realtime, e.x, res.out_x);
                end
                if (res.out_y !== e.y) begin
                    errors++;
                    $display("%t: out_y exp %0d got %0d", $realtime, e.y, res.out_y);
                end
                if (res.out_z !== e.z) begin
                    errors++;
                    $display("%t: out_z exp %0d got %0d", $realtime, e.z, res.out_z);
                end
                if (res.pixel_u !== e.u) begin
                    errors++;
                    $display("%t: pixel_u exp %0d got %0d", $realtime, e.u, res.pixel_u);
                end
                if (res.pixel_v !== e.v) begin
                    errors++;
                    $display("%t: pixel_v exp %0d got %0d", $realtime, e.v, res.pixel_v);
                end
                if (res.keep !== e.keep) begin
                    errors++;
                    $display("%t: keep exp %0b got %0b", $realtime, e.keep, res.keep);
                end
                if (res.out_end !== e.last) begin
                    errors++;
                    $display("%t: out_end exp %0b got %0b", $realtime, e.last, res.out_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt.valid && pt.ready) || (res.valid && res.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // Directed rows. Under reset registers fx=fy=cx=cy=0, so every pixel is 0,0 and
    // the box (u 300..400, v 200..300) rejects it. The same rows are replayed under a
    // 640x480 camera (f=500 px, centre 320,240) where they hit the centre, the exact
    // right box edge, plain misses, both saturation limits and depth <= 0.
    t_row dir_rows[] = '{
        '{16'sd0,      16'sd0,      16'sd256,    1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd0,      16'sd0,      -16'sd1,     1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd32767,  16'sd0,      16'sd1,      1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{-16'sd32768, 16'sd0,      16'sd1,      1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd0,      16'sd32767,  16'sd1,      1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd0,      -16'sd32768, 16'sd1,      1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd16,     16'sd0,      16'sd25,     1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd17,     16'sd0,      16'sd25,     1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{-16'sd10,    16'sd12,     16'sd25,     1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd256,    16'sd0,      16'sd256,    1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0}
    };

    // identity rotation, zero translation
    localparam logic [63:0] ROW_X = 64'h0000_0000_0000_4000;
    localparam logic [63:0] ROW_Y = 64'h0000_0000_4000_0000;
    localparam logic [63:0] ROW_Z = 64'h0000_4000_0000_0000;
    // fx=fy=500, cx=320, cy=240 in Q12.4
    localparam logic [63:0] CAM_VGA = {16'd3840, 16'd5120, 16'd8000, 16'd8000};
    localparam logic [63:0] BOX_VGA = {16'd480, 16'd640, 16'd0, 16'd0};

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_point random_point();
        t_point p;
        if ($urandom_range(99) < 70) begin
            // scene point in front of the camera, mostly near the optical axis
            p.z = 16'($urandom_range(32767, 1));
            p.x = 16'($signed(17'($urandom_range(2 * p.z)) - 17'(p.z)));
            p.y = 16'($signed(17'($urandom_range(2 * p.z)) - 17'(p.z)));
        end else begin
            p.x = 16'($urandom());
            p.y = 16'($urandom());
            p.z = 16'($urandom());
        end
        p.last = ($urandom_range(15) == 0);
        return p;
    endfunction

    initial begin
        t_point p;
        idle_mode = IDLE_NONE;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        pt.valid = 1'b0; pt.point_x = '0; pt.point_y = '0; pt.point_z = '0;
        pt.cloud_end = 1'b0;
        row0_q = ROW0_RST; row1_q = ROW1_RST; row2_q = ROW2_RST;
        intr_q = INTR_RST; box_q = BOX_RST;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: load_regs(ROW_X, ROW_Y, ROW_Z, CAM_VGA, BOX_VGA);
                    2: load_regs('0, '0, '0, '0, '0);
                    3: load_regs('1, '1, '1, '1, '1);
                    // camera with a flipped box: nothing may be kept
                    4: load_regs(ROW_X, ROW_Y, ROW_Z, CAM_VGA,
                                 {16'd0, 16'd0, 16'd480, 16'd640});
                    // mixed rotation and offsets, full-scale intrinsics
                    5: load_regs(64'h0100_2000_1000_3000, 64'hff00_c000_3000_1000,
                                 64'h0400_3000_1000_e000,
                                 {16'hffff, 16'hffff, 16'hffff, 16'hffff},
                                 {16'hffff, 16'hffff, 16'h0, 16'h0});
                    default: load_regs(rand64(), rand64(), rand64(), rand64(), rand64());
                endcase
                // unmapped indexes must leave the registers alone
                write_reg(REG_SPARE + CFG_IDX_W'(ph % 3), rand64());
            end
            idle_mode = t_idle'(ph % 4);

            // directed rows: typed results under reset, model-checked under the camera
            if (ph <= 1) begin
                foreach (dir_rows[i]) begin
                    p = '{x: dir_rows[i].x, y: dir_rows[i].y, z: dir_rows[i].z,
                          last: dir_rows[i].last};
                    send_point(p);
                    if (ph == 0 && dir_rows[i].typed) begin
                        pixel_queue[pixel_queue.size() - 1].u    = dir_rows[i].u;
                        pixel_queue[pixel_queue.size() - 1].v    = dir_rows[i].v;
                        pixel_queue[pixel_queue.size() - 1].keep = dir_rows[i].keep;
                    end
                end
            end

            if (ph > 0) begin
                for (int n = 0; n < RAND_PER_PHASE; n++)
                    send_point(random_point());
            end
            @(negedge i_clk);
            pt.valid <= 1'b0;
        end

        wait_drained();
        $display("Covered %0d points over %0d register settings and four idle patterns,",
                 points_sent, NUM_PHASES);
        $display("%0d results checked, %0d inside the box.", pixels_seen, kept_seen);
        if (errors == 0 && pixel_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pixel_queue.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lpbf_pkg.sv
rtl/lpbf_pt_if.sv
rtl/lpbf_res_if.sv
rtl/lpbf_xform.sv
rtl/lpbf_div.sv
rtl/lidar_point_box_filter.sv
tb/lidar_point_box_filter_test.sv
